>>> hw/rtl/wbps_pkg.sv
// Shared types and constants for the wildcard byte pattern scanner.
// No dependencies; every other file imports this package.

package wbps_pkg;

    localparam int MAX_PATTERN_BYTES_DEF = 16;
    localparam int PATTERN_BYTES_STORED  = 16;

    localparam logic [7:0] WILDCARD_BYTE = 8'h2A;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int ADDR_W      = 32;
    localparam int LEN_W       = 5;

    localparam logic [CFG_INDEX_W-1:0] REG_SCAN_START    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCAN_END      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LEN   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH  = 3'd4;

    typedef struct packed {
        logic [7:0] mem_byte;
        logic       stream_last;
    } scan_req_t;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] match_address;
    } scan_rsp_t;

    // per-cell view of the pattern length
    typedef struct packed {
        logic in_use;     // position lies inside the active pattern
        logic final_pos;  // position is the last byte of the pattern
    } cell_ctrl_t;

endpackage

>>> hw/rtl/wbps_cell.sv
// One pattern position of the scan chain: compares the stream byte with its
// pattern byte and holds the progress bit handed to the next cell.
// Depends on wbps_pkg.

module wbps_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              clear,
    input  wbps_pkg::cell_ctrl_t ctrl,
    input  logic              alive_in,
    input  logic [7:0]        data_byte,
    input  logic [7:0]        pattern_byte,
    output logic              progress,
    output logic              final_hit
);
    import wbps_pkg::*;

    logic progress_reg;
    logic progress_next;
    logic hit;

    assign hit = ctrl.in_use && alive_in &&
                 ((pattern_byte == data_byte) || (pattern_byte == WILDCARD_BYTE));

    assign final_hit = hit && ctrl.final_pos;

    always_comb
    begin
        progress_next = progress_reg;
        if (advance)
        begin
            progress_next = clear ? 1'b0 : (hit && !ctrl.final_pos);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            progress_reg <= 1'b0;
        end
        else
        begin
            progress_reg <= progress_next;
        end
    end

    assign progress = progress_reg;

endmodule

>>> hw/rtl/wbps_out_buf.sv
// Two-entry result buffer between the scan chain and the output channel.
// Depends on wbps_pkg.

module wbps_out_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  wbps_pkg::scan_rsp_t  push_data,
    output logic                 push_ready,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output wbps_pkg::scan_rsp_t  pop_data
);
    import wbps_pkg::*;

    localparam logic [1:0] Full = 2'd2;

    scan_rsp_t  entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != Full);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];

    assign do_push = push && push_ready;
    assign do_pop  = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> hw/rtl/wildcard_byte_pattern_scan.sv
// Top level of the wildcard byte pattern scanner: config registers, scan
// counters, the chain of pattern cells and the result buffer.
// Depends on wbps_pkg, wbps_cell and wbps_out_buf.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------
//  in      | in        | in_valid / in_ready    | in_req  (mem_byte, last)
//  out     | out       | out_valid / out_ready  | out_rsp (found, address)
//  cfg     | in        | cfg_write_en           | cfg_index, cfg_data
//
// One byte per cycle while in_ready is high; every cell compares its pattern byte in the same cycle.
// A result appears in the buffer in the cycle after the byte that causes it.
// The two-entry result buffer keeps input flowing while one result waits;
// in_ready drops only when both entries are held.
// Reset clears progress bits, offset, done flag and registers to zero.

module wildcard_byte_pattern_scan #(
    parameter int MAX_PATTERN_BYTES = wbps_pkg::MAX_PATTERN_BYTES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  wbps_pkg::scan_req_t                 in_req,
    output logic                                out_valid,
    input  logic                                out_ready,
    output wbps_pkg::scan_rsp_t                 out_rsp,
    input  logic                                cfg_write_en,
    input  logic [wbps_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import wbps_pkg::*;

    localparam logic [6:0] MaxLen = 7'(MAX_PATTERN_BYTES);

    logic [ADDR_W-1:0]     start_reg;
    logic [ADDR_W-1:0]     end_reg;
    logic [LEN_W-1:0]      len_reg;
    logic [CFG_DATA_W-1:0] pat_low_reg;
    logic [CFG_DATA_W-1:0] pat_high_reg;

    logic [ADDR_W-1:0]     offset_reg;
    logic [ADDR_W-1:0]     offset_next;
    logic                  done_reg;
    logic                  done_next;

    logic                          accept;
    logic                          start_ok;
    logic                          len_ok;
    logic [MAX_PATTERN_BYTES-1:0]  progress;
    logic [MAX_PATTERN_BYTES-1:0]  final_hits;
    logic                          matched;
    logic                          push;
    logic                          push_ready;
    scan_rsp_t                     push_data;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg    <= '0;
            end_reg      <= '0;
            len_reg      <= '0;
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_SCAN_START:   start_reg    <= cfg_data[ADDR_W-1:0];
                REG_SCAN_END:     end_reg      <= cfg_data[ADDR_W-1:0];
                REG_PATTERN_LEN:  len_reg      <= cfg_data[LEN_W-1:0];
                REG_PATTERN_LOW:  pat_low_reg  <= cfg_data;
                REG_PATTERN_HIGH: pat_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign accept   = in_valid && in_ready;
    assign in_ready = push_ready;

    assign start_ok = (start_reg < end_reg) && (offset_reg < (end_reg - start_reg));
    assign len_ok   = (len_reg != '0) && ({2'b00, len_reg} <= MaxLen);

    genvar i;
    generate
        for (i = 0; i < MAX_PATTERN_BYTES; i++)
        begin : g_cell
            logic [7:0] pat_byte;
            logic       alive;
            cell_ctrl_t ctrl;

            if (i < 8)
            begin : g_low
                assign pat_byte = pat_low_reg[8*i +: 8];
            end
            else if (i < PATTERN_BYTES_STORED)
            begin : g_high
                assign pat_byte = pat_high_reg[8*(i-8) +: 8];
            end
            else
            begin : g_none
                assign pat_byte = 8'h00;
            end

            if (i == 0)
            begin : g_head
                assign alive = start_ok;
            end
            else
            begin : g_link
                assign alive = progress[i-1];
            end

            assign ctrl.in_use    = len_ok && (7'(i) < {2'b00, len_reg});
            assign ctrl.final_pos = len_ok && ({2'b00, len_reg} == 7'(i + 1));

            wbps_cell u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .advance      (accept),
                .clear        (in_req.stream_last),
                .ctrl         (ctrl),
                .alive_in     (alive),
                .data_byte    (in_req.mem_byte),
                .pattern_byte (pat_byte),
                .progress     (progress[i]),
                .final_hit    (final_hits[i])
            );
        end
    endgenerate

    assign matched = |final_hits;

    // first match wins; a scan without one reports on its final byte
    assign push = accept && !done_reg && (matched || in_req.stream_last);

    always_comb
    begin
        push_data.found         = matched;
        push_data.match_address = '0;
        if (matched)
        begin
            push_data.match_address = start_reg + offset_reg
                                      - {{(ADDR_W-LEN_W){1'b0}}, len_reg} + 32'd1;
        end
    end

    always_comb
    begin
        offset_next = offset_reg;
        done_next   = done_reg;
        if (accept)
        begin
            if (in_req.stream_last)
            begin
                offset_next = '0;
                done_next   = 1'b0;
            end
            else
            begin
                if (offset_reg != '1)
                begin
                    offset_next = offset_reg + 32'd1;
                end
                if (matched)
                begin
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            offset_reg <= offset_next;
            done_reg   <= done_next;
        end
    end

    wbps_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (out_valid),
        .pop_ready  (out_ready),
        .pop_data   (out_rsp)
    );

endmodule

>>> hw/rtl/wbps_checker.sv
// Port-level checks for the wildcard byte pattern scanner, bound to the top.
// Depends on wbps_pkg and wildcard_byte_pattern_scan.

module wbps_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_ready,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  wbps_pkg::scan_rsp_t  out_rsp
);
    import wbps_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_rsp))
    else $error("result changed or dropped while stalled");

    // a no-match report carries address zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_rsp.found |-> out_rsp.match_address == '0)
    else $error("no-match result with non-zero address");

    // an empty result buffer never holds off requests
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
    else $error("request stalled with no result pending");

endmodule

bind wildcard_byte_pattern_scan wbps_checker u_wbps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp)
);
